// File: rtl/core/tlfs_pkg.sv
// Shared types and codes for the three-level feedback scheduler.
// No dependencies; tlfs_ctrl, tlfs_dp, the top level and the checker refer to this package.
`default_nettype none
package tlfs_pkg;

  localparam logic [1:0] ST_ACCEPT  = 2'd0;
  localparam logic [1:0] ST_REFUSE  = 2'd1;
  localparam logic [1:0] ST_IDLE    = 2'd2;
  localparam logic [1:0] ST_RAN     = 2'd3;

  localparam logic [1:0] REG_QUANT0 = 2'd0;
  localparam logic [1:0] REG_QUANT1 = 2'd1;
  localparam logic [1:0] REG_QUANT2 = 2'd2;
  localparam logic [1:0] REG_BOOST  = 2'd3;

  localparam logic [1:0] LEVEL_TOP    = 2'd0;
  localparam logic [1:0] LEVEL_MID    = 2'd1;
  localparam logic [1:0] LEVEL_LOWEST = 2'd2;

  localparam logic       FUNC_ARRIVE = 1'b0;
  localparam logic       FUNC_TICK   = 1'b1;

  typedef struct packed {
    logic take;       // latch the accepted input beat
    logic arr;        // run the arrival
    logic rem_start;  // start time modulo boost period
    logic brun;       // boost the running task
    logic drd;        // pop head of level 1 or 2
    logic dwr;        // move popped task to level 0
    logic prd;        // pop the next task to run
    logic pwr;        // load the running task
    logic rrd;        // read the task record
    logic rex;        // run one unit, post the result
  } cmd_t;

  typedef struct packed {
    logic in_func;
    logic rem_done;
    logic boost_now;
    logic drain_more;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

// File: rtl/core/tlfs_if.sv
// Handshake channels of the scheduler: input item and result item.
// Depends on nothing.
`default_nettype none
interface tlfs_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [5:0]  arrive_task;
  logic [15:0] arrive_burst;
  modport source (output valid, func, arrive_task, arrive_burst, input ready);
  modport sink   (input valid, func, arrive_task, arrive_burst, output ready);
endinterface

interface tlfs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  ran_task;
  logic [1:0]  ran_level;
  logic        first_run;
  logic        completed;
  logic        demoted;
  logic        preempted;
  logic        boosted;
  logic [31:0] tick_time;
  modport source (output valid, status, ran_task, ran_level, first_run, completed,
                  demoted, preempted, boosted, tick_time, input ready);
  modport sink   (input valid, status, ran_task, ran_level, first_run, completed,
                  demoted, preempted, boosted, tick_time, output ready);
endinterface
`default_nettype wire

// File: rtl/core/tlfs_rem.sv
// Bit-serial remainder unit: dividend modulo a 16-bit divisor, one bit a cycle.
// Standalone; used by the datapath for the boost period check.
`default_nettype none
module tlfs_rem #(
  parameter int TIME_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [TIME_BITS-1:0] dividend,
  input  wire logic [15:0]          divisor,
  output logic                      done,
  output logic                      zero
);
  localparam int CNT_W = $clog2(TIME_BITS + 1);

  logic [TIME_BITS-1:0] shift;
  logic [16:0]          rem;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic [16:0]          trial;

  assign trial = {rem[15:0], shift[TIME_BITS-1]};
  assign zero  = (rem == 17'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(TIME_BITS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift <= dividend;
      rem   <= '0;
    end else if (busy) begin
      shift <= shift << 1;
      rem   <= (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/tlfs_ctrl.sv
// Sequencer of the scheduler: walks arrival and tick steps, drives datapath commands.
// Depends on tlfs_pkg.
`default_nettype none
module tlfs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire tlfs_pkg::sts_t sts,
  output tlfs_pkg::cmd_t     cmd
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ARR  = 4'd1;
  localparam logic [3:0] S_REM  = 4'd2;
  localparam logic [3:0] S_BRUN = 4'd3;
  localparam logic [3:0] S_DRD  = 4'd4;
  localparam logic [3:0] S_DWR  = 4'd5;
  localparam logic [3:0] S_PRD  = 4'd6;
  localparam logic [3:0] S_PWR  = 4'd7;
  localparam logic [3:0] S_RRD  = 4'd8;
  localparam logic [3:0] S_REX  = 4'd9;

  logic [3:0] state, state_next;
  logic       accept;

  assign in_ready = (state == S_IDLE) && !sts.out_busy;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    state_next    = state;
    cmd.take      = accept;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (sts.in_func == tlfs_pkg::FUNC_ARRIVE) begin
            state_next = S_ARR;
          end else begin
            cmd.rem_start = 1'b1;
            state_next    = S_REM;
          end
        end
      end
      S_ARR: begin
        cmd.arr    = 1'b1;
        state_next = S_IDLE;
      end
      S_REM: begin
        if (sts.rem_done) state_next = S_BRUN;
      end
      S_BRUN: begin
        cmd.brun   = 1'b1;
        state_next = (sts.boost_now && sts.drain_more) ? S_DRD : S_PRD;
      end
      S_DRD: begin
        cmd.drd    = 1'b1;
        state_next = S_DWR;
      end
      S_DWR: begin
        cmd.dwr    = 1'b1;
        state_next = sts.drain_more ? S_DRD : S_PRD;
      end
      S_PRD: begin
        cmd.prd    = 1'b1;
        state_next = S_PWR;
      end
      S_PWR: begin
        cmd.pwr    = 1'b1;
        state_next = S_RRD;
      end
      S_RRD: begin
        cmd.rrd    = 1'b1;
        state_next = S_REX;
      end
      S_REX: begin
        cmd.rex    = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end
endmodule
`default_nettype wire

// File: rtl/core/tlfs_dp.sv
// Scheduler datapath: task records, level rings, running task, time and result beat.
// Depends on tlfs_pkg and tlfs_rem.
`default_nettype none
module tlfs_dp #(
  parameter int MAX_TASKS  = 64,
  parameter int BURST_BITS = 16,
  parameter int TIME_BITS  = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire tlfs_pkg::cmd_t cmd,
  output tlfs_pkg::sts_t      sts,
  input  wire logic           in_func,
  input  wire logic [5:0]     in_task,
  input  wire logic [15:0]    in_burst,
  input  wire logic           wr_en,
  input  wire logic [1:0]     wr_index,
  input  wire logic [15:0]    wr_data,
  input  wire logic           out_take,
  output logic                o_valid,
  output logic [1:0]          o_status,
  output logic [5:0]          o_task,
  output logic [1:0]          o_level,
  output logic                o_first,
  output logic                o_done,
  output logic                o_demo,
  output logic                o_pre,
  output logic                o_boost,
  output logic [31:0]         o_time
);
  localparam int TW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int QD = 3 * MAX_TASKS;
  localparam int QA = $clog2(QD);

  // configuration
  logic [7:0]  quant0, quant1, quant2;
  logic [15:0] boost_ival;

  always_ff @(posedge clk) begin
    if (rst) begin
      quant0     <= 8'd2;
      quant1     <= 8'd4;
      quant2     <= 8'd8;
      boost_ival <= 16'd20;
    end else if (wr_en) begin
      case (wr_index)
        tlfs_pkg::REG_QUANT0: quant0     <= wr_data[7:0];
        tlfs_pkg::REG_QUANT1: quant1     <= wr_data[7:0];
        tlfs_pkg::REG_QUANT2: quant2     <= wr_data[7:0];
        tlfs_pkg::REG_BOOST:  boost_ival <= wr_data;
        default: ;
      endcase
    end
  end

  // latched input beat
  logic [5:0]  p_task;
  logic [15:0] p_burst;
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      p_task  <= in_task;
      p_burst <= in_burst;
    end
  end

  // scheduler state
  logic [MAX_TASKS-1:0]  active;
  logic [TW-1:0]         head [3];
  logic [TW-1:0]         tail [3];
  logic [CW-1:0]         count [3];
  logic [TW-1:0]         running;
  logic                  rv;
  logic [7:0]            slice;
  logic [TIME_BITS-1:0]  time_now;
  logic                  picked;
  logic                  boost_flag;

  // remainder unit for the boost check
  logic rem_zero;
  tlfs_rem #(.TIME_BITS(TIME_BITS)) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.rem_start),
    .dividend (time_now),
    .divisor  (boost_ival),
    .done     (sts.rem_done),
    .zero     (rem_zero)
  );

  logic boost_now;
  assign boost_now = (time_now != '0) && (boost_ival != 16'd0) && rem_zero;

  // arrival checks
  logic [TW-1:0]         a_id;
  logic [BURST_BITS-1:0] a_burst;
  logic                  a_ok;
  assign a_id    = TW'(p_task);
  assign a_burst = BURST_BITS'(p_burst);
  assign a_ok    = (32'(p_task) < 32'(MAX_TASKS)) && (a_burst != '0) &&
                   !active[a_id] && (count[0] < CW'(MAX_TASKS));

  // task record memories
  logic [BURST_BITS-1:0] rem_mem [MAX_TASKS];
  logic [1:0]            lvl_mem [MAX_TASKS];
  logic                  st_mem  [MAX_TASKS];
  logic [BURST_BITS-1:0] rem_rd;
  logic [1:0]            lvl_rd;
  logic                  st_rd;

  // queue ring memory
  logic [TW-1:0] q_mem [QD];
  logic [TW-1:0] q_rd;

  // run step
  logic [BURST_BITS-1:0] new_rem;
  logic [7:0]            slice_inc;
  logic [7:0]            quant;
  logic [1:0]            down_lv;
  logic                  r_done, r_demo, r_pre;
  assign new_rem   = rem_rd - 1'b1;
  assign slice_inc = (slice < 8'd255) ? slice + 8'd1 : slice;
  assign down_lv   = (lvl_rd < tlfs_pkg::LEVEL_LOWEST) ? lvl_rd + 2'd1
                                                       : tlfs_pkg::LEVEL_LOWEST;
  always_comb begin
    case (lvl_rd)
      tlfs_pkg::LEVEL_TOP: quant = quant0;
      tlfs_pkg::LEVEL_MID: quant = quant1;
      default:             quant = quant2;
    endcase
  end
  assign r_done = (new_rem == '0);
  assign r_demo = !r_done && (slice_inc >= quant);
  assign r_pre  = !r_done && !r_demo &&
                  (((lvl_rd == tlfs_pkg::LEVEL_MID) && (count[0] != '0)) ||
                   ((lvl_rd >= tlfs_pkg::LEVEL_LOWEST) &&
                    ((count[0] != '0) || (count[1] != '0))));

  // push and pop ports, at most one of each per cycle
  logic          push_en, pop_en;
  logic [1:0]    push_lv, pop_lv;
  logic [TW-1:0] push_task;

  always_comb begin
    push_en   = 1'b0;
    push_lv   = tlfs_pkg::LEVEL_TOP;
    push_task = a_id;
    pop_en    = 1'b0;
    pop_lv    = tlfs_pkg::LEVEL_TOP;
    if (cmd.arr && a_ok) begin
      push_en = 1'b1;
    end
    if (cmd.brun && boost_now && rv) begin
      push_en   = 1'b1;
      push_task = running;
    end
    if (cmd.dwr) begin
      push_en   = 1'b1;
      push_task = q_rd;
    end
    if (cmd.rex && rv && (r_demo || r_pre)) begin
      push_en   = 1'b1;
      push_task = running;
      push_lv   = r_demo ? down_lv
                         : ((lvl_rd > tlfs_pkg::LEVEL_LOWEST) ? tlfs_pkg::LEVEL_LOWEST
                                                               : lvl_rd);
    end
    if (cmd.drd) begin
      pop_en = 1'b1;
      pop_lv = (count[1] != '0) ? tlfs_pkg::LEVEL_MID : tlfs_pkg::LEVEL_LOWEST;
    end
    if (cmd.prd && !rv) begin
      if (count[0] != '0) begin
        pop_en = 1'b1;
      end else if (count[1] != '0) begin
        pop_en = 1'b1;
        pop_lv = tlfs_pkg::LEVEL_MID;
      end else if (count[2] != '0) begin
        pop_en = 1'b1;
        pop_lv = tlfs_pkg::LEVEL_LOWEST;
      end
    end
  end

  logic          push_ok;
  logic [QA-1:0] push_addr, pop_addr;
  assign push_ok   = push_en && (count[push_lv] < CW'(MAX_TASKS));
  assign push_addr = QA'(push_lv) * QA'(MAX_TASKS) + QA'(tail[push_lv]);
  assign pop_addr  = QA'(pop_lv) * QA'(MAX_TASKS) + QA'(head[pop_lv]);

  always_ff @(posedge clk) begin
    if (push_ok) q_mem[push_addr] <= push_task;
    if (pop_en)  q_rd <= q_mem[pop_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
    end else begin
      if (push_ok) begin
        tail[push_lv]  <= (tail[push_lv] == TW'(MAX_TASKS - 1)) ? '0
                                                                : tail[push_lv] + 1'b1;
        count[push_lv] <= count[push_lv] + 1'b1;
      end
      if (pop_en) begin
        head[pop_lv]  <= (head[pop_lv] == TW'(MAX_TASKS - 1)) ? '0
                                                              : head[pop_lv] + 1'b1;
        count[pop_lv] <= count[pop_lv] - 1'b1;
      end
    end
  end

  // task record writes and reads
  always_ff @(posedge clk) begin
    if (cmd.arr && a_ok) begin
      rem_mem[a_id] <= a_burst;
      lvl_mem[a_id] <= tlfs_pkg::LEVEL_TOP;
      st_mem[a_id]  <= 1'b0;
    end
    if (cmd.brun && boost_now && rv) lvl_mem[running] <= tlfs_pkg::LEVEL_TOP;
    if (cmd.dwr) lvl_mem[q_rd] <= tlfs_pkg::LEVEL_TOP;
    if (cmd.rex && rv) begin
      rem_mem[running] <= new_rem;
      st_mem[running]  <= 1'b1;
      if (r_demo) lvl_mem[running] <= down_lv;
    end
    if (cmd.rrd) begin
      rem_rd <= rem_mem[running];
      lvl_rd <= lvl_mem[running];
      st_rd  <= st_mem[running];
    end
  end

  // control state of the running task
  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= '0;
      running    <= '0;
      rv         <= 1'b0;
      slice      <= 8'd0;
      time_now   <= '0;
      picked     <= 1'b0;
      boost_flag <= 1'b0;
      o_valid    <= 1'b0;
    end else begin
      if (out_take) o_valid <= 1'b0;
      if (cmd.arr) begin
        if (a_ok) active[a_id] <= 1'b1;
        o_valid <= 1'b1;
      end
      if (cmd.brun) begin
        boost_flag <= boost_now;
        if (boost_now && rv) begin
          rv    <= 1'b0;
          slice <= 8'd0;
        end
      end
      if (cmd.prd) begin
        picked <= pop_en;
        if (!rv) slice <= 8'd0;
      end
      if (cmd.pwr && picked) begin
        running <= q_rd;
        rv      <= 1'b1;
      end
      if (cmd.rex) begin
        o_valid  <= 1'b1;
        time_now <= time_now + 1'b1;
        if (rv) begin
          if (r_done) begin
            active[running] <= 1'b0;
            rv    <= 1'b0;
            slice <= 8'd0;
          end else if (r_demo || r_pre) begin
            rv    <= 1'b0;
            slice <= 8'd0;
          end else begin
            slice <= slice_inc;
          end
        end
      end
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (cmd.arr) begin
      o_status <= a_ok ? tlfs_pkg::ST_ACCEPT : tlfs_pkg::ST_REFUSE;
      o_task   <= 6'd0;
      o_level  <= 2'd0;
      o_first  <= 1'b0;
      o_done   <= 1'b0;
      o_demo   <= 1'b0;
      o_pre    <= 1'b0;
      o_boost  <= 1'b0;
      o_time   <= 32'(time_now);
    end
    if (cmd.rex) begin
      o_status <= rv ? tlfs_pkg::ST_RAN : tlfs_pkg::ST_IDLE;
      o_task   <= rv ? 6'(running) : 6'd0;
      o_level  <= rv ? lvl_rd : 2'd0;
      o_first  <= rv && !st_rd;
      o_done   <= rv && r_done;
      o_demo   <= rv && r_demo;
      o_pre    <= rv && r_pre;
      o_boost  <= boost_flag;
      o_time   <= 32'(time_now);
    end
  end

  assign sts.in_func    = in_func;
  assign sts.boost_now  = boost_now;
  assign sts.drain_more = (count[1] != '0) || (count[2] != '0);
  assign sts.out_busy   = o_valid;
endmodule
`default_nettype wire

// File: rtl/core/three_level_feedback_scheduler_unit.sv
// Top level of the three-level feedback scheduler.
// Depends on tlfs_pkg, tlfs_if, tlfs_ctrl and tlfs_dp.
//
// One item at a time. An arrival beat is handled in the arrival step. A tick
// beat runs the bit-serial remainder of the time against the boost period, then
// the boost step, then a pop and a push for every task moved out of level 1 or 2
// by a boost, then the pick, load, record read and run steps.
// A new beat is taken once the previous result has been taken.
// Configuration may be written whenever no beat is in flight.
`default_nettype none
module three_level_feedback_scheduler_unit #(
  parameter int MAX_TASKS  = 64,
  parameter int BURST_BITS = 16,
  parameter int TIME_BITS  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  tlfs_in_if.sink          item,
  tlfs_out_if.source       result,
  input  wire logic        wr_en,
  input  wire logic [1:0]  wr_index,
  input  wire logic [15:0] wr_data
);
  tlfs_pkg::cmd_t cmd;
  tlfs_pkg::sts_t sts;

  tlfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tlfs_dp #(
    .MAX_TASKS  (MAX_TASKS),
    .BURST_BITS (BURST_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_func  (item.func),
    .in_task  (item.arrive_task),
    .in_burst (item.arrive_burst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .out_take (result.valid && result.ready),
    .o_valid  (result.valid),
    .o_status (result.status),
    .o_task   (result.ran_task),
    .o_level  (result.ran_level),
    .o_first  (result.first_run),
    .o_done   (result.completed),
    .o_demo   (result.demoted),
    .o_pre    (result.preempted),
    .o_boost  (result.boosted),
    .o_time   (result.tick_time)
  );
endmodule
`default_nettype wire

// File: rtl/core/tlfs_checker.sv
// Port-level checks of the scheduler top level, bound in below.
// Depends on tlfs_pkg and three_level_feedback_scheduler_unit.
`default_nettype none
module tlfs_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] status,
  input wire logic [5:0] ran_task,
  input wire logic       first_run,
  input wire logic       completed,
  input wire logic       demoted,
  input wire logic       preempted,
  input wire logic       boosted
);
  // a waiting result beat stays
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result beat dropped");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_arr: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == tlfs_pkg::ST_ACCEPT || status == tlfs_pkg::ST_REFUSE) |->
    ran_task == 6'd0 && !first_run && !completed && !demoted && !preempted && !boosted)
    else $error("arrival result carries tick fields");

  a_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == tlfs_pkg::ST_IDLE |->
    !first_run && !completed && !demoted && !preempted)
    else $error("idle tick reports task events");

  // one end of slice at most
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({completed, demoted, preempted}))
    else $error("conflicting run events");
endmodule

bind three_level_feedback_scheduler_unit tlfs_checker u_tlfs_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .status    (result.status),
  .ran_task  (result.ran_task),
  .first_run (result.first_run),
  .completed (result.completed),
  .demoted   (result.demoted),
  .preempted (result.preempted),
  .boosted   (result.boosted)
);
`default_nettype wire
